// ===== hw/rtl/spk_pkg.sv =====
// ----------------------------------------------------------------------------
// spk_pkg
// Shared types, constants and round functions for the Speck 32/64 core.
// ----------------------------------------------------------------------------
package spk_pkg;

    localparam int ROUNDS_DEF = 22;
    localparam int KEY_WORDS  = 4;
    localparam int WORD_W     = 16;
    localparam int CFG_IDX_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 8'd3;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic  operation;
        t_word block_high;
        t_word block_low;
    } t_in;

    typedef struct packed {
        t_word out_high;
        t_word out_low;
    } t_out;

    typedef struct packed {
        t_word x;
        t_word y;
    } t_pair;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        t_word                data;
    } t_cfg_wr;

    function automatic t_word ror7(input t_word v);
        ror7 = {v[6:0], v[15:7]};
    endfunction

    function automatic t_word rol7(input t_word v);
        rol7 = {v[8:0], v[15:9]};
    endfunction

    function automatic t_word ror2(input t_word v);
        ror2 = {v[1:0], v[15:2]};
    endfunction

    function automatic t_word rol2(input t_word v);
        rol2 = {v[13:0], v[15:14]};
    endfunction

    function automatic t_pair fwd_round(input t_pair p, input t_word k);
        t_word a;
        a = (ror7(p.x) + p.y) ^ k;
        fwd_round.x = a;
        fwd_round.y = rol2(p.y) ^ a;
    endfunction

    function automatic t_pair inv_round(input t_pair p, input t_word k);
        t_word b;
        t_word a;
        b = ror2(p.y ^ p.x);
        a = (p.x ^ k) - b;
        inv_round.x = rol7(a);
        inv_round.y = b;
    endfunction

endpackage

// ===== hw/rtl/spk_key_sched.sv =====
// ----------------------------------------------------------------------------
// spk_key_sched
// Key registers and iterative round-key expansion, one round key per cycle.
// ----------------------------------------------------------------------------
module spk_key_sched #(
    parameter int ROUNDS = spk_pkg::ROUNDS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  spk_pkg::t_cfg_wr i_cfg,
    output logic            o_busy,
    output spk_pkg::t_word  o_rk [ROUNDS]
);

    localparam int KW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    spk_pkg::t_word r_key [spk_pkg::KEY_WORDS];
    logic           r_start;
    logic           r_active;
    logic [KW-1:0]  r_cnt;
    spk_pkg::t_word r_cur;
    spk_pkg::t_word r_l [spk_pkg::KEY_WORDS-1];
    spk_pkg::t_word r_rk [ROUNDS];

    logic           w_key_wr;
    spk_pkg::t_pair n_pair;

    assign w_key_wr = i_cfg.valid && (i_cfg.index == spk_pkg::REG_KEY_WORD_0 ||
                                      i_cfg.index == spk_pkg::REG_KEY_WORD_1 ||
                                      i_cfg.index == spk_pkg::REG_KEY_WORD_2 ||
                                      i_cfg.index == spk_pkg::REG_KEY_WORD_3);

    always_comb begin
        spk_pkg::t_pair p;
        p.x    = r_l[0];
        p.y    = r_cur;
        n_pair = spk_pkg::fwd_round(p, spk_pkg::WORD_W'(r_cnt));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < spk_pkg::KEY_WORDS; i++) begin
                r_key[i] <= '0;
            end
            r_start  <= 1'b1;
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_start <= w_key_wr;
            if (w_key_wr) begin
                case (i_cfg.index)
                    spk_pkg::REG_KEY_WORD_0: r_key[0] <= i_cfg.data;
                    spk_pkg::REG_KEY_WORD_1: r_key[1] <= i_cfg.data;
                    spk_pkg::REG_KEY_WORD_2: r_key[2] <= i_cfg.data;
                    spk_pkg::REG_KEY_WORD_3: r_key[3] <= i_cfg.data;
                    default: ;
                endcase
            end
            if (w_key_wr) begin
                r_active <= 1'b0;
            end else if (r_start) begin
                r_active <= (ROUNDS > 1);
                r_cnt    <= '0;
            end else if (r_active) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == KW'(ROUNDS - 2)) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_start) begin
            r_cur    <= r_key[0];
            r_l[0]   <= r_key[1];
            r_l[1]   <= r_key[2];
            r_l[2]   <= r_key[3];
            r_rk[0]  <= r_key[0];
        end else if (r_active) begin
            r_cur    <= n_pair.y;
            r_l[0]   <= r_l[1];
            r_l[1]   <= r_l[2];
            r_l[2]   <= n_pair.x;
            r_rk[KW'(r_cnt + 1'b1)] <= n_pair.y;
        end
    end

    assign o_busy = r_start | r_active | w_key_wr;
    assign o_rk   = r_rk;

endmodule

// ===== hw/rtl/speck32_64_block_cipher_core.sv =====
// ----------------------------------------------------------------------------
// speck32_64_block_cipher_core
// Speck 32/64 encrypt/decrypt core, one round per pipeline stage.
// An accepted start passes through every round stage register before o_strobe.
// Throughput: one block per cycle while busy is low; the receiver cannot stall the pipeline.
// Reset and each key write rebuild the round keys, one per cycle from the key
// schedule loop; busy stays high after reset or a key write until expansion ends.
// ----------------------------------------------------------------------------
module speck32_64_block_cipher_core #(
    parameter int ROUNDS = spk_pkg::ROUNDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  spk_pkg::t_in                   i_in,
    output logic                           o_strobe,
    output spk_pkg::t_out                  o_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [spk_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  spk_pkg::t_word                 i_cfg_data
);

    spk_pkg::t_cfg_wr w_cfg;
    spk_pkg::t_word   w_rk [ROUNDS];
    logic             w_accept;

    logic             r_vld [ROUNDS];
    logic             r_op  [ROUNDS];
    spk_pkg::t_pair   r_dat [ROUNDS];

    assign o_cfg_ready = 1'b1;
    assign w_cfg.valid = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    spk_key_sched #(
        .ROUNDS (ROUNDS)
    ) u_key_sched (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .o_busy  (busy),
        .o_rk    (w_rk)
    );

    assign w_accept = start && !busy;

    for (genvar s = 0; s < ROUNDS; s++) begin : g_stage
        logic           w_vld;
        logic           w_op;
        spk_pkg::t_pair w_dat;
        spk_pkg::t_word w_key;

        if (s == 0) begin : g_first
            assign w_vld   = w_accept;
            assign w_op    = i_in.operation;
            assign w_dat.x = i_in.block_high;
            assign w_dat.y = i_in.block_low;
        end else begin : g_next
            assign w_vld = r_vld[s-1];
            assign w_op  = r_op[s-1];
            assign w_dat = r_dat[s-1];
        end

        assign w_key = (w_op == spk_pkg::OP_DECRYPT) ? w_rk[ROUNDS-1-s] : w_rk[s];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_op[s]  <= w_op;
            r_dat[s] <= (w_op == spk_pkg::OP_DECRYPT) ? spk_pkg::inv_round(w_dat, w_key)
                                                      : spk_pkg::fwd_round(w_dat, w_key);
        end
    end

    assign o_strobe       = r_vld[ROUNDS-1];
    assign o_out.out_high = r_dat[ROUNDS-1].x;
    assign o_out.out_low  = r_dat[ROUNDS-1].y;

    a_accept_to_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##ROUNDS o_strobe)
        else $error("accepted transaction did not reach the output");

    a_strobe_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept, ROUNDS))
        else $error("result strobe without a matching transaction");

    a_key_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && i_cfg_index == spk_pkg::REG_KEY_WORD_0) |=> busy)
        else $error("key write did not hold off new transactions");

endmodule
